// ----- rtl/sip_date_field_parser_defines.svh -----
// assertion macros shared by the date parser modules
`ifndef SIP_DATE_FIELD_PARSER_DEFINES_SVH
`define SIP_DATE_FIELD_PARSER_DEFINES_SVH

// concurrent assertion, sampled on clk_i, off while rst_ni is low
`define SDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define SDP_ASSERT_NEXT(lbl, pre, post, msg) \
  `SDP_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ----- rtl/sdp_pkg.sv -----
// shared types, constants and helpers of the date field parser
`timescale 1ns / 1ps

package sdp_pkg;

  // character constants
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  // result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEarly = 2'd1;
  localparam logic [1:0] StBad   = 2'd2;

  // token queue between classifier and parser
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  typedef logic [FifoPtrW-1:0] fifo_ptr_t;
  typedef logic [FifoCntW-1:0] fifo_cnt_t;

  // classified character
  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] digit;
    logic       is_ws;
    logic       is_dig;
    logic       is_colon;
    logic       is_comma;
    logic       is_mon1;
    logic       eos;
  } token_t;

  function automatic logic first_letter_known(input logic [7:0] c);
    return (c == "J") || (c == "F") || (c == "M") || (c == "A") ||
           (c == "S") || (c == "O") || (c == "N") || (c == "D");
  endfunction

  // month index from the three letters, case sensitive
  function automatic logic [3:0] decode_month(input logic [7:0] l1,
                                              input logic [7:0] l2,
                                              input logic [7:0] l3);
    logic [3:0] m;
    case (l1)
      "J":     m = (l2 == "a") ? 4'd0 : ((l3 == "n") ? 4'd5 : 4'd6);
      "F":     m = 4'd1;
      "M":     m = (l3 == "r") ? 4'd2 : 4'd4;
      "A":     m = (l2 == "p") ? 4'd3 : 4'd7;
      "S":     m = 4'd8;
      "O":     m = 4'd9;
      "N":     m = 4'd10;
      default: m = 4'd11;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/sdp_if.sv -----
// channel interfaces of the date field parser
`timescale 1ns / 1ps

interface sdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_string;

  modport source (output valid, output ch, output end_of_string, input ready);
  modport sink   (input valid, input ch, input end_of_string, output ready);
endinterface

interface sdp_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [1:0]  status;

  modport source (output valid, output day, output month, output year, output hour,
                  output minute, output second, output status, input ready);
  modport sink   (input valid, input day, input month, input year, input hour,
                  input minute, input second, input status, output ready);
endinterface

// ----- rtl/sip_date_field_parser.sv -----
// top level of the date field parser
// usage:
//   in_i carries one ascii character per transaction (ch) plus end_of_string on
//   the last character of a date string; out_o carries one parsed result per
//   string: day, month, year, hour, minute, second and a status code
//   (ok, string ended before minutes, bad character)
// throughput: one character per cycle sustained; in_i.ready stays high while
//   the four-entry token queue has room, independent of parser state
// result path: the character that completes, fails or ends the string is written
//   into the queue when it is taken, and the parser steps it into the result
//   register once it reaches the head of the queue and out_o is not stalled
// reset: rst_ni clears the queue, the parser phase, all accumulators and the
//   result valid flag; the parser then waits for leading whitespace or a date
// stall: when out_o.ready is low the result is held, the parser stops pulling
//   tokens and the queue absorbs up to four more characters before in_i.ready
//   drops; no transaction is dropped or repeated
// after a result, characters up to end_of_string are consumed silently
`timescale 1ns / 1ps

module sip_date_field_parser (
  input logic       clk_i,
  input logic       rst_ni,
  sdp_in_if.sink    in_i,
  sdp_out_if.source out_o
);

  // classifier to queue
  logic            fr_valid, fr_ready;
  sdp_pkg::token_t fr_tok;

  // queue to parser
  logic            bk_valid, bk_ready;
  sdp_pkg::token_t bk_tok;

  // character classification, purely combinational
  sdp_front u_front (
    .in_i        (in_i),
    .tok_valid_o (fr_valid),
    .tok_o       (fr_tok),
    .tok_ready_i (fr_ready)
  );

  // decouples input acceptance from result back-pressure
  sdp_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_tok_i   (fr_tok),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_tok_o   (bk_tok)
  );

  // parser state machine and result register
  sdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (bk_valid),
    .tok_ready_o (bk_ready),
    .tok_i       (bk_tok),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/sdp_front.sv -----
// input side: accepts characters and classifies them into tokens
`timescale 1ns / 1ps

module sdp_front (
  sdp_in_if.sink          in_i,
  output logic            tok_valid_o,
  output sdp_pkg::token_t tok_o,
  input  logic            tok_ready_i
);

  logic [7:0] c;

  assign c           = in_i.ch;
  assign in_i.ready  = tok_ready_i;
  assign tok_valid_o = in_i.valid;

  always_comb begin
    tok_o.ch       = c;
    tok_o.digit    = c[3:0];
    tok_o.is_ws    = (c == sdp_pkg::ChSpace) || (c == sdp_pkg::ChTab);
    tok_o.is_dig   = (c >= sdp_pkg::ChZero) && (c <= sdp_pkg::ChNine);
    tok_o.is_colon = (c == sdp_pkg::ChColon);
    tok_o.is_comma = (c == sdp_pkg::ChComma);
    tok_o.is_mon1  = sdp_pkg::first_letter_known(c);
    tok_o.eos      = in_i.end_of_string;
  end

endmodule

// ----- rtl/sdp_fifo.sv -----
// short token queue between the classifier and the parser
`timescale 1ns / 1ps
`include "sip_date_field_parser_defines.svh"

module sdp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  sdp_pkg::token_t wr_tok_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output sdp_pkg::token_t rd_tok_o
);

  sdp_pkg::token_t    mem_q [sdp_pkg::FifoDepth];
  sdp_pkg::fifo_ptr_t wr_ptr_q, rd_ptr_q;
  sdp_pkg::fifo_cnt_t count_q;
  logic               push, pop;

  assign wr_ready_o = (count_q != sdp_pkg::fifo_cnt_t'(sdp_pkg::FifoDepth));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_tok_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= sdp_pkg::fifo_ptr_t'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= sdp_pkg::fifo_ptr_t'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        count_q <= sdp_pkg::fifo_cnt_t'(count_q + 1'b1);
      end else if (pop && !push) begin
        count_q <= sdp_pkg::fifo_cnt_t'(count_q - 1'b1);
      end
    end
  end

  `SDP_ASSERT(a_fifo_bound, count_q <= sdp_pkg::fifo_cnt_t'(sdp_pkg::FifoDepth), "fifo overfilled")
  `SDP_ASSERT_NEXT(a_fifo_inc, push && !pop, count_q == sdp_pkg::fifo_cnt_t'($past(count_q) + 1'b1), "fifo count did not grow")
  `SDP_ASSERT_NEXT(a_fifo_dec, pop && !push, count_q == sdp_pkg::fifo_cnt_t'($past(count_q) - 1'b1), "fifo count did not shrink")

endmodule

// ----- rtl/sdp_back.sv -----
// parser side: steps the date state machine per token and holds the result register
`timescale 1ns / 1ps
`include "sip_date_field_parser_defines.svh"

module sdp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  output logic            tok_ready_o,
  input  sdp_pkg::token_t tok_i,
  sdp_out_if.source       out_o
);

  typedef enum logic [4:0] {
    PH_START      = 5'd0,
    PH_WEEKDAY    = 5'd1,
    PH_PRE_DAY    = 5'd2,
    PH_DAY        = 5'd3,
    PH_PRE_MONTH  = 5'd4,
    PH_MON2       = 5'd5,
    PH_MON3       = 5'd6,
    PH_PRE_YEAR   = 5'd7,
    PH_YEAR       = 5'd8,
    PH_PRE_HOUR   = 5'd9,
    PH_HOUR2      = 5'd10,
    PH_PRE_SEP    = 5'd11,
    PH_PRE_MIN    = 5'd12,
    PH_MIN2       = 5'd13,
    PH_PRE_COLON  = 5'd14,
    PH_PRE_SEC    = 5'd15,
    PH_SEC2       = 5'd16
  } phase_e;

  phase_e      phase_q, phase_d, eff;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] letters_q, letters_d;
  logic [6:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic        done_q;
  logic        emit;
  logic [1:0]  st;
  logic        pop;

  logic        out_valid_q;
  logic [6:0]  out_day_q, out_hour_q, out_minute_q, out_second_q;
  logic [3:0]  out_month_q;
  logic [13:0] out_year_q;
  logic [1:0]  out_status_q;

  assign tok_ready_o = !out_valid_q || out_o.ready;
  assign pop         = tok_valid_i && tok_ready_o;

  always_comb begin
    cnt_d     = cnt_q;
    letters_d = letters_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    emit      = 1'b0;
    st        = sdp_pkg::StOk;

    // a non-digit ends the day or a long enough year and is reread by the next part
    eff = phase_q;
    if (phase_q == PH_DAY && !tok_i.is_dig) begin
      eff = PH_PRE_MONTH;
    end else if (phase_q == PH_YEAR && !tok_i.is_dig && cnt_q >= 3'd2) begin
      eff = PH_PRE_HOUR;
    end
    phase_d = eff;

    if (!done_q) begin
      unique case (eff)
        PH_START: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_dig) begin
              day_d   = 7'(tok_i.digit);
              phase_d = PH_DAY;
            end else if (tok_i.is_comma) begin
              phase_d = PH_PRE_DAY;
            end else begin
              phase_d = PH_WEEKDAY;
            end
          end
        end
        PH_WEEKDAY: begin
          if (tok_i.is_comma) begin
            phase_d = PH_PRE_DAY;
          end
        end
        PH_PRE_DAY: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_dig) begin
              day_d   = 7'(tok_i.digit);
              phase_d = PH_DAY;
            end else begin
              emit = 1'b1;
              st   = sdp_pkg::StBad;
            end
          end
        end
        PH_DAY: begin
          day_d   = 7'(day_q * 7'd10 + 7'(tok_i.digit));
          phase_d = PH_PRE_MONTH;
        end
        PH_PRE_MONTH: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_mon1) begin
              letters_d = {tok_i.ch, 8'h00};
              phase_d   = PH_MON2;
            end else begin
              emit = 1'b1;
              st   = sdp_pkg::StBad;
            end
          end
        end
        PH_MON2: begin
          letters_d = {letters_q[15:8], tok_i.ch};
          phase_d   = PH_MON3;
        end
        PH_MON3: begin
          month_d = sdp_pkg::decode_month(letters_q[15:8], letters_q[7:0], tok_i.ch);
          phase_d = PH_PRE_YEAR;
        end
        PH_PRE_YEAR: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_dig) begin
              year_d  = 14'(tok_i.digit);
              cnt_d   = 3'd1;
              phase_d = PH_YEAR;
            end else begin
              emit = 1'b1;
              st   = sdp_pkg::StBad;
            end
          end
        end
        PH_YEAR: begin
          if (tok_i.is_dig) begin
            year_d = 14'(year_q * 14'd10 + 14'(tok_i.digit));
            cnt_d  = 3'(cnt_q + 1'b1);
            if (cnt_q >= 3'd3) begin
              phase_d = PH_PRE_HOUR;
            end
          end else begin
            // fewer than two year digits
            emit = 1'b1;
            st   = sdp_pkg::StBad;
          end
        end
        PH_PRE_HOUR: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_dig) begin
              hour_d  = 7'(tok_i.digit);
              phase_d = PH_HOUR2;
            end else begin
              emit = 1'b1;
              st   = sdp_pkg::StBad;
            end
          end
        end
        PH_HOUR2: begin
          if (tok_i.is_dig) begin
            hour_d  = 7'(hour_q * 7'd10 + 7'(tok_i.digit));
            phase_d = PH_PRE_SEP;
          end else begin
            emit = 1'b1;
            st   = sdp_pkg::StBad;
          end
        end
        PH_PRE_SEP: begin
          // any non-blank character serves as separator
          if (!tok_i.is_ws) begin
            phase_d = PH_PRE_MIN;
          end
        end
        PH_PRE_MIN: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_dig) begin
              minute_d = 7'(tok_i.digit);
              phase_d  = PH_MIN2;
            end else begin
              emit = 1'b1;
              st   = sdp_pkg::StBad;
            end
          end
        end
        PH_MIN2: begin
          if (tok_i.is_dig) begin
            minute_d = 7'(minute_q * 7'd10 + 7'(tok_i.digit));
            phase_d  = PH_PRE_COLON;
          end else begin
            emit = 1'b1;
            st   = sdp_pkg::StBad;
          end
        end
        PH_PRE_COLON: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_colon) begin
              phase_d = PH_PRE_SEC;
            end else begin
              second_d = '0;
              emit     = 1'b1;
              st       = sdp_pkg::StOk;
            end
          end
        end
        PH_PRE_SEC: begin
          if (!tok_i.is_ws) begin
            if (tok_i.is_dig) begin
              second_d = 7'(tok_i.digit);
              phase_d  = PH_SEC2;
            end else begin
              emit = 1'b1;
              st   = sdp_pkg::StBad;
            end
          end
        end
        PH_SEC2: begin
          if (tok_i.is_dig) begin
            second_d = 7'(second_q * 7'd10 + 7'(tok_i.digit));
            emit     = 1'b1;
            st       = sdp_pkg::StOk;
          end else begin
            emit = 1'b1;
            st   = sdp_pkg::StBad;
          end
        end
        default: begin
          emit = 1'b1;
          st   = sdp_pkg::StBad;
        end
      endcase

      // string ended with nothing emitted yet
      if (!emit && tok_i.eos) begin
        emit = 1'b1;
        if (phase_d == PH_PRE_COLON || phase_d == PH_PRE_SEC || phase_d == PH_SEC2) begin
          st = sdp_pkg::StOk;
          if (phase_d != PH_PRE_COLON) begin
            second_d = '0;
          end
        end else begin
          st = sdp_pkg::StEarly;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      cnt_q     <= '0;
      letters_q <= '0;
      day_q     <= '0;
      month_q   <= '0;
      year_q    <= '0;
      hour_q    <= '0;
      minute_q  <= '0;
      second_q  <= '0;
      done_q    <= 1'b0;
    end else if (pop) begin
      if (tok_i.eos) begin
        phase_q   <= PH_START;
        cnt_q     <= '0;
        letters_q <= '0;
        day_q     <= '0;
        month_q   <= '0;
        year_q    <= '0;
        hour_q    <= '0;
        minute_q  <= '0;
        second_q  <= '0;
        done_q    <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        letters_q <= letters_d;
        day_q     <= day_d;
        month_q   <= month_d;
        year_q    <= year_d;
        hour_q    <= hour_d;
        minute_q  <= minute_d;
        second_q  <= second_d;
        done_q    <= done_q || emit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      out_day_q    <= day_d;
      out_month_q  <= month_d;
      out_year_q   <= year_d;
      out_hour_q   <= hour_d;
      out_minute_q <= minute_d;
      out_second_q <= second_d;
      out_status_q <= st;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.day    = out_day_q;
  assign out_o.month  = out_month_q;
  assign out_o.year   = out_year_q;
  assign out_o.hour   = out_hour_q;
  assign out_o.minute = out_minute_q;
  assign out_o.second = out_second_q;
  assign out_o.status = out_status_q;

  `SDP_ASSERT_NEXT(a_eos_restart, pop && tok_i.eos, phase_q == PH_START && !done_q, "parser did not restart after end of string")
  `SDP_ASSERT(a_done_silent, (pop && done_q) |-> !emit, "result after parse already finished")
  `SDP_ASSERT(a_no_overwrite, (out_valid_q && !out_o.ready) |-> !pop, "result register overwritten while stalled")

endmodule

// ----- dv/sip_date_field_parser_tb.sv -----
// self-checking testbench of the date field parser, with a character-level parse predictor
`timescale 1ns / 1ps

module sip_date_field_parser_tb;

  localparam int ItemTarget = 1850;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int HoldAtItem = 150;

  // phases of the date grammar, in the order the string is read
  typedef enum logic [4:0] {
    PhStart, PhWeekday, PhPreDay, PhDay, PhPreMonth, PhMon2, PhMon3, PhPreYear,
    PhYear, PhPreHour, PhHour2, PhPreSep, PhPreMin, PhMin2, PhPreColon, PhPreSec,
    PhSec2
  } parse_phase_e;

  typedef enum logic [3:0] {
    MonJan, MonFeb, MonMar, MonApr, MonMay, MonJun,
    MonJul, MonAug, MonSep, MonOct, MonNov, MonDec
  } month_e;

  typedef struct packed {
    logic [6:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [1:0]  status;
  } date_fields_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } date_char_t;

  typedef logic [7:0] char_q_t[$];

  string day_names[7]   = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
  string month_names[12] = '{"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                             "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
  string month_initials  = "JFMASOND";

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sdp_in_if  in_if ();
  sdp_out_if out_if ();

  sip_date_field_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  // characters waiting to be driven and parse results still owed by the block
  date_char_t   pending_chars[$];
  date_fields_t expected_dates[$];

  int queued_cnt     = 0;
  int taken_cnt      = 0;
  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // parse predictor: its own copy of the parser state, one call per character
  // ---------------------------------------------------------------------------
  parse_phase_e ps_phase;
  int           ps_cnt;
  logic [7:0]   ps_l1, ps_l2;
  int           ps_day, ps_year, ps_hour, ps_min, ps_sec;
  logic [3:0]   ps_mon;
  bit           ps_done;

  function automatic void clear_parse_state();
    ps_phase = PhStart;
    ps_cnt   = 0;
    ps_l1    = '0;
    ps_l2    = '0;
    ps_day   = 0;
    ps_mon   = '0;
    ps_year  = 0;
    ps_hour  = 0;
    ps_min   = 0;
    ps_sec   = 0;
    ps_done  = 1'b0;
  endfunction

  // advances the parser by one character, returns 1 when a result comes out
  function automatic bit parse_date_char(input logic [7:0] c, input logic eos,
                                         output date_fields_t res);
    bit         fired, again, ws, dig;
    logic [1:0] code;
    int         d, guard;
    fired = 1'b0;
    again = 1'b1;
    guard = 0;
    code  = sdp_pkg::StOk;
    ws    = (c == sdp_pkg::ChSpace) || (c == sdp_pkg::ChTab);
    dig   = (c >= sdp_pkg::ChZero) && (c <= sdp_pkg::ChNine);
    d     = int'(c) - int'(sdp_pkg::ChZero);
    res   = '0;

    // a character that closes a field is handed on to the next phase
    while (!ps_done && again && guard < 3) begin
      again = 1'b0;
      guard++;
      case (ps_phase)
        PhStart: begin
          if (!ws) begin
            if (dig) begin
              ps_day = d; ps_cnt = 1; ps_phase = PhDay;
            end else if (c == sdp_pkg::ChComma) begin
              ps_phase = PhPreDay;
            end else begin
              ps_phase = PhWeekday;
            end
          end
        end
        PhWeekday: begin
          if (c == sdp_pkg::ChComma) ps_phase = PhPreDay;
        end
        PhPreDay: begin
          if (!ws) begin
            if (dig) begin
              ps_day = d; ps_cnt = 1; ps_phase = PhDay;
            end else begin
              fired = 1'b1; code = sdp_pkg::StBad;
            end
          end
        end
        PhDay: begin
          if (dig) begin
            ps_day = ps_day * 10 + d; ps_cnt = 2; ps_phase = PhPreMonth;
          end else begin
            ps_phase = PhPreMonth; again = 1'b1;
          end
        end
        PhPreMonth: begin
          if (!ws) begin
            if (c inside {"J", "F", "M", "A", "S", "O", "N", "D"}) begin
              ps_l1 = c; ps_phase = PhMon2;
            end else begin
              fired = 1'b1; code = sdp_pkg::StBad;
            end
          end
        end
        PhMon2: begin
          ps_l2 = c; ps_phase = PhMon3;
        end
        PhMon3: begin
          case (ps_l1)
            "J":     ps_mon = (ps_l2 == "a") ? MonJan : ((c == "n") ? MonJun : MonJul);
            "F":     ps_mon = MonFeb;
            "M":     ps_mon = (c == "r") ? MonMar : MonMay;
            "A":     ps_mon = (ps_l2 == "p") ? MonApr : MonAug;
            "S":     ps_mon = MonSep;
            "O":     ps_mon = MonOct;
            "N":     ps_mon = MonNov;
            default: ps_mon = MonDec;
          endcase
          ps_phase = PhPreYear;
        end
        PhPreYear: begin
          if (!ws) begin
            if (dig) begin
              ps_year = d; ps_cnt = 1; ps_phase = PhYear;
            end else begin
              fired = 1'b1; code = sdp_pkg::StBad;
            end
          end
        end
        PhYear: begin
          if (dig && ps_cnt < 4) begin
            ps_year = ps_year * 10 + d;
            ps_cnt++;
            if (ps_cnt >= 4) ps_phase = PhPreHour;
          end else if (ps_cnt >= 2) begin
            ps_phase = PhPreHour; again = 1'b1;
          end else begin
            fired = 1'b1; code = sdp_pkg::StBad;
          end
        end
        PhPreHour: begin
          if (!ws) begin
            if (dig) begin
              ps_hour = d; ps_phase = PhHour2;
            end else begin
              fired = 1'b1; code = sdp_pkg::StBad;
            end
          end
        end
        PhHour2: begin
          if (dig) begin
            ps_hour = ps_hour * 10 + d; ps_phase = PhPreSep;
          end else begin
            fired = 1'b1; code = sdp_pkg::StBad;
          end
        end
        PhPreSep: begin
          // any one non-blank character separates hour from minute
          if (!ws) ps_phase = PhPreMin;
        end
        PhPreMin: begin
          if (!ws) begin
            if (dig) begin
              ps_min = d; ps_phase = PhMin2;
            end else begin
              fired = 1'b1; code = sdp_pkg::StBad;
            end
          end
        end
        PhMin2: begin
          if (dig) begin
            ps_min = ps_min * 10 + d; ps_phase = PhPreColon;
          end else begin
            fired = 1'b1; code = sdp_pkg::StBad;
          end
        end
        PhPreColon: begin
          if (!ws) begin
            if (c == sdp_pkg::ChColon) begin
              ps_phase = PhPreSec;
            end else begin
              ps_sec = 0; fired = 1'b1; code = sdp_pkg::StOk;
            end
          end
        end
        PhPreSec: begin
          if (!ws) begin
            if (dig) begin
              ps_sec = d; ps_phase = PhSec2;
            end else begin
              fired = 1'b1; code = sdp_pkg::StBad;
            end
          end
        end
        PhSec2: begin
          if (dig) begin
            ps_sec = ps_sec * 10 + d; fired = 1'b1; code = sdp_pkg::StOk;
          end else begin
            fired = 1'b1; code = sdp_pkg::StBad;
          end
        end
        default: begin
          fired = 1'b1; code = sdp_pkg::StBad;
        end
      endcase
    end

    // string ends with no result yet: ok once the minutes are in, else early
    if (!fired && eos && !ps_done) begin
      fired = 1'b1;
      if (ps_phase >= PhPreColon) begin
        if (ps_phase != PhPreColon) ps_sec = 0;
        code = sdp_pkg::StOk;
      end else begin
        code = sdp_pkg::StEarly;
      end
    end

    if (fired) begin
      res.day    = 7'(ps_day);
      res.month  = ps_mon;
      res.year   = 14'(ps_year);
      res.hour   = 7'(ps_hour);
      res.minute = 7'(ps_min);
      res.second = 7'(ps_sec);
      res.status = code;
    end

    if (eos) clear_parse_state();
    else if (fired) ps_done = 1'b1;
    return fired;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_str(ref char_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  task automatic push_digits(ref char_q_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(sdp_pkg::ChZero + 8'($urandom_range(0, 9)));
  endtask

  // up to max_n blanks, spaces and tabs mixed
  task automatic push_ws(ref char_q_t q, input int max_n);
    int n;
    n = $urandom_range(0, max_n);
    for (int i = 0; i < n; i++) begin
      q.push_back($urandom_range(0, 1) ? sdp_pkg::ChSpace : sdp_pkg::ChTab);
    end
  endtask

  // hands one whole string to the driver, end_of_string on its last character
  task automatic queue_chars(input char_q_t q);
    date_char_t item;
    foreach (q[i]) begin
      item.ch  = q[i];
      item.eos = (i == q.size() - 1);
      pending_chars.push_back(item);
      queued_cnt++;
    end
  endtask

  task automatic queue_text(input string s);
    char_q_t q;
    push_str(q, s);
    queue_chars(q);
  endtask

  // one random date string: mostly well formed, some cut short, corrupted or noise
  task automatic queue_random_date(output int counted);
    char_q_t q;
    int      roll, kind, ydigits, pos;
    kind = $urandom_range(0, 99);

    push_ws(q, 2);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      push_str(q, day_names[$urandom_range(0, 6)]);
      q.push_back(sdp_pkg::ChComma);
      push_ws(q, 2);
    end else if (roll < 55) begin
      q.push_back(sdp_pkg::ChComma);
    end

    push_digits(q, $urandom_range(1, 2));
    push_ws(q, 2);

    // month: usually a real name, sometimes a known initial with any two bytes
    if ($urandom_range(0, 99) < 85) begin
      push_str(q, month_names[$urandom_range(0, 11)]);
    end else begin
      q.push_back(month_initials[$urandom_range(0, 7)]);
      q.push_back(8'($urandom_range(0, 255)));
      q.push_back(8'($urandom_range(0, 255)));
    end
    push_ws(q, 2);

    // a four-digit year may run straight into the hour
    ydigits = $urandom_range(2, 4);
    push_digits(q, ydigits);
    if (ydigits == 4 && $urandom_range(0, 3) == 0) begin
      // no blank before the hour
    end else begin
      q.push_back(sdp_pkg::ChSpace);
      push_ws(q, 1);
    end

    push_digits(q, 2);
    push_ws(q, 1);
    if ($urandom_range(0, 99) < 80) begin
      q.push_back(sdp_pkg::ChColon);
    end else begin
      q.push_back(8'($urandom_range(33, 255)));
    end
    push_ws(q, 1);
    push_digits(q, 2);
    if ($urandom_range(0, 99) < 75) begin
      push_ws(q, 1);
      q.push_back(sdp_pkg::ChColon);
      push_ws(q, 1);
      push_digits(q, 2);
    end

    if (kind < 80 && kind >= 65) begin
      // cut short anywhere
      q = q[0:$urandom_range(0, q.size() - 1)];
    end else if (kind < 92 && kind >= 80) begin
      pos = $urandom_range(0, q.size() - 1);
      q[pos] = 8'($urandom_range(0, 255));
    end else if (kind >= 92) begin
      q.delete();
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
    end

    // zone suffix on all but noise strings; after a complete date it has no effect
    if (kind < 92 && $urandom_range(0, 1)) push_str(q, " GMT");
    counted = q.size();
    queue_chars(q);
  endtask

  task automatic wait_all_taken();
    while (taken_cnt != queued_cnt) @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    while (expected_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input bit has_want,
                                 input date_fields_t want, input date_fields_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (has_want) begin
        $display("%0t %s: expected day %0d month %0d year %0d time %0d:%0d:%0d status %0d",
                 $realtime, what, want.day, want.month, want.year, want.hour,
                 want.minute, want.second, want.status);
      end else begin
        $display("%0t %s: expected nothing", $realtime, what);
      end
      $display("%0t %s: actual   day %0d month %0d year %0d time %0d:%0d:%0d status %0d",
               $realtime, what, got.day, got.month, got.year, got.hour,
               got.minute, got.second, got.status);
    end
  endtask

  // ---------------------------------------------------------------------------
  // character driver: pulls from pending_chars, idles at the sender rate
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.ch            <= '0;
      in_if.end_of_string <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      // slot is free: offer the next character or idle this cycle
      if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_if.valid                        <= 1'b1;
        {in_if.ch, in_if.end_of_string}    <= pending_chars.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long hold-off once, early in the no-idle phase, so the token queue fills
  // up and in_i.ready drops while the driver keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && taken_cnt == HoldAtItem) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitors: each accepted character feeds the predictor, each accepted
  // result is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : char_monitor
    date_fields_t want;
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (parse_date_char(in_if.ch, in_if.end_of_string, want)) begin
        expected_dates.push_back(want);
      end
      taken_cnt <= taken_cnt + 1;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    date_fields_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.day, out_if.month, out_if.year, out_if.hour,
             out_if.minute, out_if.second, out_if.status};
      if (expected_dates.size() == 0) begin
        report_mismatch("result with none pending", 1'b0, got, got);
      end else begin
        want = expected_dates.pop_front();
        if (got !== want) report_mismatch("result mismatch", 1'b1, want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase_items, got_items;
    clear_parse_state();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // weekday text cut short before any day digit
    queue_text("x");
    // largest day and year, a four-digit year running straight into the hour, any
    // character as the time separator, string ending right after the minutes
    queue_text("99Dec999995959");
    // unknown month letter, then a character that is only skipped
    queue_text("1Qz");
    // zero fields, string ending within the seconds
    queue_text("0Mar00 00:00:0");
    // single-digit day then blank then a digit where the month belongs
    queue_text("5 7Jan 2020 10:10");
    // two-digit year then blank then the hour
    queue_text("5 Jan 20 11:22:33");

    // idle mix: none, sender 65, receiver 65, both 26
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      phase_items = 0;
      while (phase_items < ItemTarget / 4) begin
        queue_random_date(got_items);
        phase_items += got_items;
      end
      wait_all_taken();
      // sender stays quiet until every owed result is back
      if (p == 1) wait_results_drained();
    end

    wait_all_taken();
    wait_results_drained();
    // let any stray result show up
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sip_date_field_parser.f -----
+incdir+rtl
rtl/sdp_pkg.sv
rtl/sdp_if.sv
rtl/sdp_front.sv
rtl/sdp_fifo.sv
rtl/sdp_back.sv
rtl/sip_date_field_parser.sv
dv/sip_date_field_parser_tb.sv
